>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file inp_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

>>> hw/rtl/inp_pkg.sv
// Package for the non-directional intra predictor: mode codes, commands
// and the smooth weight table. Depends on nothing.
package inp_pkg;
	localparam int MaxSide = 64;
	localparam int SampleBits = 12;
	localparam int PosW = 6;

	localparam logic [1:0] CMD_ABOVE = 2'd0;
	localparam logic [1:0] CMD_LEFT = 2'd1;
	localparam logic [1:0] CMD_CORNER = 2'd2;
	localparam logic [1:0] CMD_PREDICT = 2'd3;

	localparam logic [2:0] MODE_DC = 3'd0;
	localparam logic [2:0] MODE_V = 3'd1;
	localparam logic [2:0] MODE_H = 3'd2;
	localparam logic [2:0] MODE_PAETH = 3'd3;
	localparam logic [2:0] MODE_SMOOTH = 3'd4;
	localparam logic [2:0] MODE_SMOOTH_V = 3'd5;
	localparam logic [2:0] MODE_SMOOTH_H = 3'd6;

	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_WIDTH = 3'd1;
	localparam logic [2:0] REG_HEIGHT = 3'd2;
	localparam logic [2:0] REG_DEPTH = 3'd3;
	localparam logic [2:0] REG_ABOVE = 3'd4;
	localparam logic [2:0] REG_LEFT = 3'd5;

	typedef logic [SampleBits-1:0] sample_t;

	// Smooth weight for side code sc and index i.
	function automatic logic [7:0] smooth_weight(input logic [2:0] sc, input logic [5:0] i);
		logic [7:0] w4 [4];
		logic [7:0] w8 [8];
		logic [7:0] w16 [16];
		logic [7:0] w32 [32];
		logic [7:0] w64 [64];
		logic [7:0] r;
		w4 = '{8'd255, 8'd149, 8'd85, 8'd64};
		w8 = '{8'd255, 8'd197, 8'd146, 8'd105, 8'd73, 8'd50, 8'd37, 8'd32};
		w16 = '{8'd255, 8'd225, 8'd196, 8'd170, 8'd145, 8'd123, 8'd102, 8'd84,
			8'd68, 8'd54, 8'd43, 8'd33, 8'd26, 8'd20, 8'd17, 8'd16};
		w32 = '{8'd255, 8'd240, 8'd225, 8'd210, 8'd196, 8'd182, 8'd169, 8'd157,
			8'd145, 8'd133, 8'd122, 8'd111, 8'd101, 8'd92, 8'd83, 8'd74,
			8'd66, 8'd59, 8'd52, 8'd45, 8'd39, 8'd34, 8'd29, 8'd25,
			8'd21, 8'd17, 8'd14, 8'd12, 8'd10, 8'd9, 8'd8, 8'd8};
		w64 = '{8'd255, 8'd248, 8'd240, 8'd233, 8'd225, 8'd218, 8'd210, 8'd203,
			8'd196, 8'd189, 8'd182, 8'd176, 8'd169, 8'd163, 8'd156, 8'd150,
			8'd144, 8'd138, 8'd133, 8'd127, 8'd121, 8'd116, 8'd111, 8'd106,
			8'd101, 8'd96, 8'd91, 8'd86, 8'd82, 8'd77, 8'd73, 8'd69,
			8'd65, 8'd61, 8'd57, 8'd54, 8'd50, 8'd47, 8'd44, 8'd41,
			8'd38, 8'd35, 8'd32, 8'd29, 8'd27, 8'd25, 8'd22, 8'd20,
			8'd18, 8'd16, 8'd15, 8'd13, 8'd12, 8'd10, 8'd9, 8'd8,
			8'd7, 8'd6, 8'd6, 8'd5, 8'd5, 8'd4, 8'd4, 8'd4};
		case (sc)
			3'd0: r = w4[i[1:0]];
			3'd1: r = w8[i[2:0]];
			3'd2: r = w16[i[3:0]];
			3'd3: r = w32[i[4:0]];
			default: r = w64[i];
		endcase
		return r;
	endfunction
endpackage

>>> hw/rtl/inp_dc_div.sv
// Restoring divider for the DC mean: 19-bit dividend by 8-bit sample count.
// Uses inp_pkg.
module inp_dc_div (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic [18:0] dividend,
	input logic [7:0] divisor,
	output logic done,
	output logic [11:0] quotient
);
	import inp_pkg::*;
	logic [18:0] rem_q;
	logic [18:0] quo_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic [19:0] trial;

	assign trial = {rem_q, quo_q[18]} - {12'd0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd19;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!trial[19]) begin
				rem_q <= trial[18:0];
				quo_q <= {quo_q[17:0], 1'b1};
			end else begin
				rem_q <= {rem_q[17:0], quo_q[18]};
				quo_q <= {quo_q[17:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q[SampleBits-1:0];
endmodule

>>> hw/rtl/intra_nondirectional_predictor.sv
// Top level of the non-directional intra predictor.
// Depends on inp_pkg and inp_dc_div.
//
// A load transaction writes one reference sample and leaves busy low, so loads
// can follow one per cycle while no predict transaction holds busy high. A
// predict transaction for a row inside the block reads the bottom-left,
// top-right and left references from the single-port reference memories in
// the states ST_RD_BL, ST_RD_TR and ST_RD_L and starts the column scan in
// ST_EMIT. It then puts out width samples on consecutive cycles, marked by
// strobe. busy drops in the cycle that carries the last sample. DC first sums
// the left edge when it is present and the above edge when it is present,
// then adds half the count for rounding and divides when an edge is present.
// A predict row at or beyond the block height is accepted, leaves busy low and
// gives no result. Results cannot be stalled.
module intra_nondirectional_predictor (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] command,
	input logic [5:0] position,
	input logic [11:0] ref_sample,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [11:0] cfg_data,
	output logic strobe,
	output logic [5:0] out_row,
	output logic [5:0] out_column,
	output logic [11:0] pred_sample,
	output logic row_last
);
	import inp_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD_BL = 4'd1;
	localparam logic [3:0] ST_RD_TR = 4'd2;
	localparam logic [3:0] ST_RD_L = 4'd3;
	localparam logic [3:0] ST_SUM_L = 4'd4;
	localparam logic [3:0] ST_SUM_A = 4'd5;
	localparam logic [3:0] ST_DIV = 4'd6;
	localparam logic [3:0] ST_WAIT = 4'd7;
	localparam logic [3:0] ST_EMIT = 4'd8;
	localparam logic [3:0] ST_EMIT2 = 4'd9;

	// The unused mode code predicts like DC.
	localparam logic [2:0] MODE_DC_ALIAS = 3'd7;

	logic [2:0] mode_q, wcode_q, hcode_q;
	logic [1:0] depth_q;
	logic ap_q, lp_q;
	sample_t corner_q;
	sample_t above_mem [MaxSide];
	sample_t left_mem [MaxSide];
	sample_t above_rd, left_rd;
	logic [5:0] above_addr, left_addr;
	logic [3:0] st_q;
	logic [5:0] row_q, idx_q;
	logic [6:0] cnt_q;
	sample_t bl_q, tr_q, l_q, dc_q;
	logic [18:0] sum_q;
	logic [2:0] wc, hc;
	logic [6:0] w, h;
	logic [7:0] count;
	logic div_go, div_done;
	logic [11:0] div_quo;
	logic accept;
	logic load_a, load_l;
	logic [5:0] col_s1;
	logic vld_s1, last_s1;
	logic [7:0] vx, vy;
	logic [19:0] pv, ph;
	logic [20:0] psm;
	logic signed [14:0] base, dl, da, dd;
	sample_t pp, pval;

	assign wc = (wcode_q > 3'd4) ? 3'd4 : wcode_q;
	assign hc = (hcode_q > 3'd4) ? 3'd4 : hcode_q;
	assign w = 7'd4 << wc;
	assign h = 7'd4 << hc;
	assign count = (lp_q ? {1'b0, h} : 8'd0) + (ap_q ? {1'b0, w} : 8'd0);
	assign accept = start && !busy;
	assign busy = (st_q != ST_IDLE);
	assign load_a = accept && command == CMD_ABOVE;
	assign load_l = accept && command == CMD_LEFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			wcode_q <= '0;
			hcode_q <= '0;
			depth_q <= '0;
			ap_q <= 1'b0;
			lp_q <= 1'b0;
			corner_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MODE: mode_q <= cfg_data[2:0];
					REG_WIDTH: wcode_q <= cfg_data[2:0];
					REG_HEIGHT: hcode_q <= cfg_data[2:0];
					REG_DEPTH: depth_q <= cfg_data[1:0];
					REG_ABOVE: ap_q <= cfg_data[0];
					REG_LEFT: lp_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (accept && command == CMD_CORNER) corner_q <= ref_sample;
		end
	end

	// Address selection for the two single-port memories.
	always_comb begin
		above_addr = idx_q;
		left_addr = idx_q;
		if (load_a) above_addr = position;
		if (load_l) left_addr = position;
		unique case (st_q)
			ST_RD_BL: left_addr = h[5:0] - 6'd1;
			ST_RD_TR: above_addr = w[5:0] - 6'd1;
			ST_RD_L: left_addr = row_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_a) above_mem[above_addr] <= ref_sample;
		above_rd <= above_mem[above_addr];
		if (load_l) left_mem[left_addr] <= ref_sample;
		left_rd <= left_mem[left_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			idx_q <= '0;
			cnt_q <= '0;
			vld_s1 <= 1'b0;
			div_go <= 1'b0;
		end else begin
			div_go <= 1'b0;
			vld_s1 <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (accept && command == CMD_PREDICT && {1'b0, position} < h) begin
					row_q <= position;
					st_q <= ST_RD_BL;
				end
				ST_RD_BL: st_q <= ST_RD_TR;
				ST_RD_TR: begin
					bl_q <= left_rd;
					st_q <= ST_RD_L;
				end
				ST_RD_L: begin
					tr_q <= above_rd;
					idx_q <= '0;
					cnt_q <= '0;
					sum_q <= '0;
					if (mode_q == MODE_DC || mode_q == MODE_DC_ALIAS)
						st_q <= lp_q ? ST_SUM_L : (ap_q ? ST_SUM_A : ST_DIV);
					else
						st_q <= ST_EMIT;
				end
				ST_SUM_L: begin
					// Memory data belongs to the address of the previous cycle.
					if (cnt_q == 7'd0) l_q <= left_rd;
					if (cnt_q != 7'd0) sum_q <= sum_q + {7'd0, left_rd};
					idx_q <= idx_q + 6'd1;
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == h) begin
						idx_q <= '0;
						cnt_q <= '0;
						st_q <= ap_q ? ST_SUM_A : ST_DIV;
					end
				end
				ST_SUM_A: begin
					if (cnt_q == 7'd0 && !lp_q) l_q <= left_rd;
					if (cnt_q != 7'd0) sum_q <= sum_q + {7'd0, above_rd};
					idx_q <= idx_q + 6'd1;
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == w) begin
						idx_q <= '0;
						cnt_q <= '0;
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == 7'd0 && !lp_q && !ap_q) l_q <= left_rd;
					if (count == 8'd0) begin
						dc_q <= (depth_q == 2'd0) ? 12'd128 :
							(depth_q == 2'd1) ? 12'd512 : 12'd2048;
						st_q <= ST_EMIT;
					end else begin
						div_go <= 1'b1;
						sum_q <= sum_q + {12'd0, count[7:1]};
						st_q <= ST_WAIT;
					end
				end
				ST_WAIT: if (div_done) begin
					dc_q <= div_quo;
					st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (mode_q != MODE_DC && mode_q != MODE_DC_ALIAS) l_q <= left_rd;
					idx_q <= 6'd1;
					cnt_q <= 7'd1;
					vld_s1 <= 1'b1;
					col_s1 <= '0;
					last_s1 <= (w == 7'd1);
					st_q <= ST_EMIT2;
				end
				ST_EMIT2: begin
					if (cnt_q == w) begin
						st_q <= ST_IDLE;
						idx_q <= '0;
					end else begin
						idx_q <= idx_q + 6'd1;
						cnt_q <= cnt_q + 7'd1;
						vld_s1 <= 1'b1;
						col_s1 <= idx_q;
						last_s1 <= (cnt_q == w - 7'd1);
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	inp_dc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.go(div_go),
		.dividend(sum_q),
		.divisor(count),
		.done(div_done),
		.quotient(div_quo)
	);

	// Sample computation on the above value read for column col_s1.
	assign vx = smooth_weight(wc, col_s1);
	assign vy = smooth_weight(hc, row_q);
	assign pv = ({12'd0, vy} * {8'd0, above_rd})
		+ ({11'd0, 9'd256 - {1'b0, vy}} * {8'd0, bl_q});
	assign ph = ({12'd0, vx} * {8'd0, l_q})
		+ ({11'd0, 9'd256 - {1'b0, vx}} * {8'd0, tr_q});
	assign psm = {1'b0, pv} + {1'b0, ph} + 21'd256;
	assign base = $signed({3'd0, above_rd}) + $signed({3'd0, l_q}) - $signed({3'd0, corner_q});
	assign dl = base - $signed({3'd0, l_q});
	assign da = base - $signed({3'd0, above_rd});
	assign dd = base - $signed({3'd0, corner_q});

	always_comb begin
		logic [14:0] al, aa, ad;
		al = dl[14] ? 15'(-dl) : dl;
		aa = da[14] ? 15'(-da) : da;
		ad = dd[14] ? 15'(-dd) : dd;
		if (al <= aa && al <= ad) pp = l_q;
		else if (aa <= ad) pp = above_rd;
		else pp = corner_q;
	end

	always_comb begin
		logic [20:0] t;
		t = '0;
		case (mode_q)
			MODE_V: pval = above_rd;
			MODE_H: pval = l_q;
			MODE_PAETH: pval = pp;
			MODE_SMOOTH: begin
				t = psm >> 9;
				pval = t[11:0];
			end
			MODE_SMOOTH_V: begin
				t = ({1'b0, pv} + 21'd128) >> 8;
				pval = t[11:0];
			end
			MODE_SMOOTH_H: begin
				t = ({1'b0, ph} + 21'd128) >> 8;
				pval = t[11:0];
			end
			default: pval = dc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe <= 1'b0;
		else strobe <= vld_s1;
	end

	always_ff @(posedge clk) begin
		out_row <= row_q;
		out_column <= col_s1;
		pred_sample <= pval;
		row_last <= last_s1;
	end
endmodule

>>> hw/rtl/inp_checker.sv
// Port checker for the intra predictor, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module inp_checker (
	input logic clk,
	input logic arst_n,
	input logic busy,
	input logic strobe,
	input logic [5:0] out_column,
	input logic row_last
);
	`ASSERT_CLK(a_strobe_busy, clk, arst_n, strobe |-> $past(busy), "strobe without busy")
	`ASSERT_CLK(a_col_step, clk, arst_n, strobe && $past(strobe) |-> out_column == $past(out_column) + 6'd1, "column skipped")
	`ASSERT_CLK(a_first_col, clk, arst_n, strobe && !$past(strobe) |-> out_column == 6'd0, "row not from column zero")
	`ASSERT_CLK(a_last_ends, clk, arst_n, strobe && row_last |=> !strobe, "results after last")
endmodule

bind intra_nondirectional_predictor inp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .busy(busy),
	.strobe(strobe), .out_column(out_column), .row_last(row_last)
);
